// ----- rtl/apn_pkg.sv -----
// Package for the allpass notch filter: control word type, operation codes,
// register map and the fixed-point helper functions.
// No dependencies; used by every module of the block.
`default_nettype none

package apn_pkg;

   localparam int SAMPLE_W = 24;
   localparam int STATE_W  = 32;
   localparam int COEF_W   = 24;
   localparam int PROD_W   = COEF_W + STATE_W;
   localparam int ACC_W    = PROD_W + 2;
   localparam int FRAC_W   = 23;
   localparam int STEP_W   = 3;
   localparam int ADDR_W   = 4;
   localparam int DATA_W   = 32;

   localparam logic [1:0] REG_MODE   = 2'd0;
   localparam logic [1:0] REG_RADIUS = 2'd1;
   localparam logic [1:0] REG_TUNING = 2'd2;

   localparam logic [1:0] MODE_ALLPASS = 2'd0;
   localparam logic [1:0] MODE_NOTCH   = 2'd1;
   localparam logic [1:0] MODE_INVERSE = 2'd2;

   typedef enum logic {
      COEF_RADIUS,
      COEF_TUNING
   } coef_sel_type;

   typedef enum logic [1:0] {
      STATE_U1,
      STATE_U2,
      STATE_U0
   } state_sel_type;

   typedef enum logic [2:0] {
      ACC_HOLD,
      ACC_LOAD_X,
      ACC_SUB_2P,
      ACC_SUB_P,
      ACC_LOAD_AT_U2,
      ACC_ADD_P
   } acc_op_type;

   typedef enum logic [1:0] {
      JMP_NONE,
      JMP_NO_REQ,
      JMP_OUT_BUSY
   } jmp_cond_type;

   typedef struct packed {
      coef_sel_type        coef_sel;
      state_sel_type       state_sel;
      acc_op_type          acc_op;
      logic                save_at;
      logic                wr_u0;
      logic                wr_ap;
      logic                emit;
      logic                accept;
      jmp_cond_type        jmp_cond;
      logic [STEP_W-1:0]   jmp_target;
   } ctrl_type;

   // Microprogram for one sample: two sums of three terms, each rounded, then
   // the output selection and the delay line update.
   function automatic ctrl_type apn_rom(input logic [STEP_W-1:0] step);
      ctrl_type w;
      w = '{coef_sel: COEF_RADIUS, state_sel: STATE_U2, acc_op: ACC_HOLD,
            save_at: 1'b0, wr_u0: 1'b0, wr_ap: 1'b0, emit: 1'b0, accept: 1'b0,
            jmp_cond: JMP_NONE, jmp_target: '0};
      unique case (step)
         3'd0: begin
            w.coef_sel   = COEF_TUNING;
            w.state_sel  = STATE_U1;
            w.acc_op     = ACC_LOAD_X;
            w.accept     = 1'b1;
            w.jmp_cond   = JMP_NO_REQ;
            w.jmp_target = 3'd0;
         end
         3'd1: begin
            w.acc_op  = ACC_SUB_2P;
            w.save_at = 1'b1;
         end
         3'd2: w.acc_op = ACC_SUB_P;
         3'd3: w.wr_u0 = 1'b1;
         3'd4: begin
            w.state_sel = STATE_U0;
            w.acc_op    = ACC_LOAD_AT_U2;
         end
         3'd5: w.acc_op = ACC_ADD_P;
         3'd6: w.wr_ap = 1'b1;
         3'd7: begin
            w.emit       = 1'b1;
            w.jmp_cond   = JMP_OUT_BUSY;
            w.jmp_target = 3'd7;
         end
         default: w.acc_op = ACC_HOLD;
      endcase
      return w;
   endfunction

   // Round a Q.46 sum to Q.23, to nearest with ties upwards, then saturate.
   function automatic logic signed [STATE_W-1:0] round_sat32(
      input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0]          t;
      logic signed [ACC_W-FRAC_W-1:0]   q;
      logic signed [STATE_W-1:0]        r;
      t = v + ACC_W'(1 << (FRAC_W - 1));
      q = t[ACC_W-1:FRAC_W];
      if (q[ACC_W-FRAC_W-1:STATE_W-1] == '0 || q[ACC_W-FRAC_W-1:STATE_W-1] == '1) begin
         r = q[STATE_W-1:0];
      end else if (q[ACC_W-FRAC_W-1]) begin
         r = {1'b1, {(STATE_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(STATE_W-1){1'b1}}};
      end
      return r;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [STATE_W-1:0] v);
      logic signed [SAMPLE_W-1:0] r;
      if (v[STATE_W-1:SAMPLE_W-1] == '0 || v[STATE_W-1:SAMPLE_W-1] == '1) begin
         r = v[SAMPLE_W-1:0];
      end else if (v[STATE_W-1]) begin
         r = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/apn_seq.sv -----
// Microcode sequencer: step counter, control word lookup and conditional jumps.
// Depends on apn_pkg for the control word type and the program table.
`default_nettype none

module apn_seq (
   input  wire                logic clock,
   input  wire                logic reset,
   input  wire                logic req_valid,
   input  wire                logic out_busy,
   output apn_pkg::ctrl_type  ctrl
);
   import apn_pkg::*;

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   ctrl_type          word;
   logic              jump;

   always_comb begin
      word = apn_rom(step_ff);
      unique case (word.jmp_cond)
         JMP_NO_REQ:   jump = !req_valid;
         JMP_OUT_BUSY: jump = out_busy;
         default:      jump = 1'b0;
      endcase
      step_in   = jump ? word.jmp_target : step_ff + STEP_W'(1);
      ctrl      = word;
      ctrl.emit = word.emit && !jump;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/apn_datapath.sv -----
// Datapath: one shared multiplier, product register, accumulator, lattice delays
// and the output register. Depends on apn_pkg; driven by the sequencer.
`default_nettype none

module apn_datapath (
   input  wire  logic                                  clock,
   input  wire  logic                                  reset,
   input  apn_pkg::ctrl_type                           ctrl,
   input  wire  logic [1:0]                            filter_mode,
   input  wire  logic signed [apn_pkg::COEF_W-1:0]     pole_radius,
   input  wire  logic signed [apn_pkg::COEF_W-1:0]     tuning_coeff,
   input  wire  logic signed [apn_pkg::SAMPLE_W-1:0]   sample_in,
   input  wire  logic                                  rsp_stall,
   output logic                                        out_busy,
   output logic                                        rsp_valid,
   output logic signed [apn_pkg::SAMPLE_W-1:0]         rsp_sample_out
);
   import apn_pkg::*;

   logic signed [SAMPLE_W-1:0] x_ff;
   logic signed [PROD_W-1:0]   p_ff;
   logic signed [ACC_W-1:0]    acc_ff;
   logic signed [ACC_W-1:0]    acc_in;
   logic signed [ACC_W-1:0]    at_ff;
   logic signed [STATE_W-1:0]  u0_ff;
   logic signed [STATE_W-1:0]  u1_ff;
   logic signed [STATE_W-1:0]  u2_ff;
   logic signed [STATE_W-1:0]  ap_ff;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_data_ff;
   logic signed [SAMPLE_W-1:0] y;
   logic signed [COEF_W-1:0]   coef;
   logic signed [STATE_W-1:0]  state;
   logic signed [STATE_W:0]    pair;
   logic signed [ACC_W-1:0]    p_ext;
   logic signed [ACC_W-1:0]    p_dbl;

   always_comb begin
      coef  = (ctrl.coef_sel == COEF_TUNING) ? tuning_coeff : pole_radius;
      unique case (ctrl.state_sel)
         STATE_U1: state = u1_ff;
         STATE_U0: state = u0_ff;
         default:  state = u2_ff;
      endcase
      p_ext = {{2{p_ff[PROD_W-1]}}, p_ff};
      p_dbl = {p_ff[PROD_W-1], p_ff, 1'b0};
      case (ctrl.acc_op)
         ACC_LOAD_X:     acc_in = {{(ACC_W-SAMPLE_W-FRAC_W){sample_in[SAMPLE_W-1]}},
                                   sample_in, {FRAC_W{1'b0}}};
         ACC_SUB_2P:     acc_in = acc_ff - p_dbl;
         ACC_SUB_P:      acc_in = acc_ff - p_ext;
         ACC_LOAD_AT_U2: acc_in = at_ff + {{(ACC_W-STATE_W-FRAC_W){u2_ff[STATE_W-1]}},
                                           u2_ff, {FRAC_W{1'b0}}};
         ACC_ADD_P:      acc_in = acc_ff + p_ext;
         default:        acc_in = acc_ff;
      endcase
   end

   always_comb begin
      if (filter_mode == MODE_INVERSE) begin
         pair = {{(STATE_W-SAMPLE_W+1){x_ff[SAMPLE_W-1]}}, x_ff} - {ap_ff[STATE_W-1], ap_ff};
      end else begin
         pair = {{(STATE_W-SAMPLE_W+1){x_ff[SAMPLE_W-1]}}, x_ff} + {ap_ff[STATE_W-1], ap_ff};
      end
      if (filter_mode == MODE_NOTCH || filter_mode == MODE_INVERSE) begin
         y = sat24(pair[STATE_W:1]);
      end else begin
         y = sat24(ap_ff);
      end
      out_busy     = rsp_valid_ff && rsp_stall;
      rsp_valid_in = ctrl.emit || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      p_ff   <= PROD_W'(coef) * PROD_W'(state);
      acc_ff <= acc_in;
      if (ctrl.accept) begin
         x_ff <= sample_in;
      end
      if (ctrl.save_at) begin
         at_ff <= p_dbl;
      end
      if (ctrl.wr_u0) begin
         u0_ff <= round_sat32(acc_ff);
      end
      if (ctrl.wr_ap) begin
         ap_ff <= round_sat32(acc_ff);
      end
      if (ctrl.emit) begin
         rsp_data_ff <= y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         u1_ff        <= '0;
         u2_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (ctrl.emit) begin
            u2_ff <= u1_ff;
            u1_ff <= u0_ff;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;

endmodule

`default_nettype wire

// ----- rtl/allpass_notch_filter_core.sv -----
// Allpass notch filter top level: register port, sequencer and datapath.
// Depends on apn_pkg, apn_seq and apn_datapath.
// The program has eight steps around one shared 24 by 32 bit multiplier. A sample
// is taken in step 0 and its result is registered when step 7 emits; step 7 waits
// while the output is stalled, and no new sample is taken until the last is emitted.
// Synchronous reset clears the delays and the registers to mode 0, r at its maximum, a zero.
`default_nettype none

module allpass_notch_filter_core (
   input  wire  logic                                 clock,
   input  wire  logic                                 reset,
   input  wire  logic                                 req_valid,
   output logic                                       req_stall,
   input  wire  logic signed [apn_pkg::SAMPLE_W-1:0]  req_sample_in,
   output logic                                       rsp_valid,
   input  wire  logic                                 rsp_stall,
   output logic signed [apn_pkg::SAMPLE_W-1:0]        rsp_sample_out,
   input  wire  logic                                 csr_psel,
   input  wire  logic                                 csr_penable,
   input  wire  logic                                 csr_pwrite,
   input  wire  logic [apn_pkg::ADDR_W-1:0]           csr_paddr,
   input  wire  logic [apn_pkg::DATA_W-1:0]           csr_pwdata,
   output logic [apn_pkg::DATA_W-1:0]                 csr_prdata,
   output logic                                       csr_pready
);
   import apn_pkg::*;

   ctrl_type                 ctrl;
   logic                     out_busy;
   logic [1:0]               mode_ff;
   logic signed [COEF_W-1:0] radius_ff;
   logic signed [COEF_W-1:0] tuning_ff;
   logic                     wr_en;
   logic [1:0]               reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[ADDR_W-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign req_stall  = !ctrl.accept;

   always_comb begin
      unique case (reg_idx)
         REG_MODE:   csr_prdata = {{(DATA_W-2){1'b0}}, mode_ff};
         REG_RADIUS: csr_prdata = {{(DATA_W-COEF_W){radius_ff[COEF_W-1]}}, radius_ff};
         REG_TUNING: csr_prdata = {{(DATA_W-COEF_W){tuning_ff[COEF_W-1]}}, tuning_ff};
         default:    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_ALLPASS;
         radius_ff <= {1'b0, {(COEF_W-1){1'b1}}};
         tuning_ff <= '0;
      end else if (wr_en) begin
         case (reg_idx)
            REG_MODE:   mode_ff   <= csr_pwdata[1:0];
            REG_RADIUS: radius_ff <= csr_pwdata[COEF_W-1:0];
            REG_TUNING: tuning_ff <= csr_pwdata[COEF_W-1:0];
            default:    mode_ff   <= mode_ff;
         endcase
      end
   end

   apn_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_busy  (out_busy),
      .ctrl      (ctrl)
   );

   apn_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (ctrl),
      .filter_mode    (mode_ff),
      .pole_radius    (radius_ff),
      .tuning_coeff   (tuning_ff),
      .sample_in      (req_sample_in),
      .rsp_stall      (rsp_stall),
      .out_busy       (out_busy),
      .rsp_valid      (rsp_valid),
      .rsp_sample_out (rsp_sample_out)
   );

endmodule

`default_nettype wire
